[hw/rtl/utne_pkg.sv]
// Shared types and constants for the newline-expanding 8N1 transmitter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package utne_pkg;

	localparam logic [7:0]  CHAR_CR        = 8'h0D;
	localparam logic [7:0]  CHAR_LF        = 8'h0A;
	localparam int          FRAME_BITS     = 10;
	localparam int          BIT_IDX_W      = 4;
	localparam logic [15:0] BIT_PERIOD_RST = 16'd868;

	// One queued frame request: the character and whether a CR frame follows it.
	typedef struct packed {
		logic [7:0] char_val;
		logic       expand;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

[hw/rtl/utne_front.sv]
// Front end: accepts characters, tracks the carriage-return flag and classifies
// each character into a queue request. Depends on utne_pkg.
`timescale 1ns / 1ps

module utne_front import utne_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  fifo_stat_t q_stat,
	output logic       push,
	output q_entry_t   push_entry
);

	logic after_cr_q;

	assign in_ready              = !q_stat.full;
	assign push                  = in_valid && !q_stat.full;
	assign push_entry.char_val   = char_in;
	// a bare line feed gets a carriage return appended by the back end
	assign push_entry.expand     = (char_in == CHAR_LF) && !after_cr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_cr_q <= 1'b0;
		end else if (push) begin
			after_cr_q <= (char_in == CHAR_CR);
		end
	end

endmodule

[hw/rtl/utne_fifo.sv]
// Small request queue between front and back end.
// Depends on utne_pkg for the entry and status types.
`timescale 1ns / 1ps

module utne_fifo import utne_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  q_entry_t   push_entry,
	input  logic       pop,
	output q_entry_t   pop_entry,
	output fifo_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/utne_back.sv]
// Back end: serializes queued requests into 8N1 frame bits, one result per bit,
// paced by the bit period. Depends on utne_pkg.
`timescale 1ns / 1ps

module utne_back import utne_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] bit_period,
	input  fifo_stat_t  q_stat,
	input  q_entry_t    q_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        line_level,
	output logic        last_bit
);

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	state_t                state_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [BIT_IDX_W-1:0]  bit_idx_q;
	logic                  pending_cr_q;
	logic [15:0]           timer_q;
	logic                  out_valid_q;
	logic                  line_level_q;
	logic                  last_bit_q;
	logic [15:0]           period_m1;
	logic                  slot_free;
	logic                  emit;
	logic                  stop_bit;

	assign period_m1  = (bit_period == '0) ? '0 : bit_period - 16'd1;
	assign slot_free  = !out_valid_q || out_ready;
	assign emit       = (state_q == ST_SEND) && (timer_q == '0) && slot_free;
	assign stop_bit   = (bit_idx_q == BIT_IDX_W'(FRAME_BITS - 1));
	assign pop        = (state_q == ST_IDLE) && !q_stat.empty;

	assign out_valid  = out_valid_q;
	assign line_level = line_level_q;
	assign last_bit   = last_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frame_q      <= '1;
			bit_idx_q    <= '0;
			pending_cr_q <= 1'b0;
			timer_q      <= '0;
			out_valid_q  <= 1'b0;
			line_level_q <= 1'b1;
			last_bit_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// hold the previous bit on the line until its period runs out
			if (timer_q != '0) begin
				timer_q <= timer_q - 16'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						frame_q      <= {1'b1, q_entry.char_val, 1'b0};
						pending_cr_q <= q_entry.expand;
						bit_idx_q    <= '0;
						state_q      <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (emit) begin
						line_level_q <= frame_q[0];
						last_bit_q   <= stop_bit && !pending_cr_q;
						timer_q      <= period_m1;
						if (stop_bit && pending_cr_q) begin
							// follow the line feed with a carriage-return frame
							frame_q      <= {1'b1, CHAR_CR, 1'b0};
							pending_cr_q <= 1'b0;
							bit_idx_q    <= '0;
						end else begin
							frame_q   <= {1'b1, frame_q[FRAME_BITS-1:1]};
							bit_idx_q <= bit_idx_q + 1'b1;
							if (stop_bit) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/uart_tx_newline_expand.sv]
// Top level of the 8N1 transmitter with line-feed expansion.
// Depends on utne_pkg, utne_front, utne_fifo and utne_back.
//
// Usage:
//   Characters enter on in_valid/in_ready/char_in. Each frame bit leaves as one
//   request on out_valid/out_ready with line_level and last_bit; last_bit marks
//   the stop bit that ends the work caused by one character. A line feed that
//   does not follow a carriage return produces two frames (LF, then CR).
//   cfg_we/cfg_wdata write bit_period, the hold time of each line level in
//   clock cycles (a value of zero acts as one); write it only while idle.
//   A character passes the queue, then the serializer's frame register, then the
//   output register before its start bit is offered, when the back end is idle
//   and the previous stop bit has run out. Each following bit is offered once the
//   previous bit's period has run out, or later if the receiver has not taken it yet.
//   The character rate is set by the bit timer of the serializer (an expanded
//   line feed sends two frames); with bit_period below 2 the queue fetch also
//   slows each character. The queue of DEPTH requests lets the front accept
//   characters while a frame is on the line.
//   A stalled receiver holds the current bit and pauses the serializer; input is
//   still taken until the queue fills.
//   Reset: queue empty, carriage-return flag clear, line level high, bit_period
//   set to 868.
`timescale 1ns / 1ps

module uart_tx_newline_expand import utne_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        line_level,
	output logic        last_bit
);

	logic [15:0] bit_period_q;
	fifo_stat_t  q_stat;
	logic        push;
	q_entry_t    push_entry;
	logic        pop;
	q_entry_t    pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= BIT_PERIOD_RST;
		end else if (cfg_we) begin
			bit_period_q <= cfg_wdata;
		end
	end

	utne_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	utne_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.stat       (q_stat)
	);

	utne_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.bit_period (bit_period_q),
		.q_stat     (q_stat),
		.q_entry    (pop_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_level (line_level),
		.last_bit   (last_bit)
	);

	a_stat_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !q_stat.empty)
		else $error("accepted character did not reach the queue");

	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_bit) |-> line_level)
		else $error("last bit flagged on a level other than the stop bit");

endmodule

[tb/testbench.sv]
// Self-checking bench for uart_tx_newline_expand: drives characters, predicts each frame bit
// and checks line_level/last_bit in order. Depends on utne_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
	import utne_pkg::*;

	typedef enum logic [1:0] {ROW_CHAR, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [15:0] period;
		logic [7:0]  ch;
		logic        typed;   // expected bits given in the row
		logic [1:0]  frames;
		logic [19:0] bits;    // line levels, first bit sent in bit 0
	} dir_row_t;

	typedef struct packed {
		logic level;
		logic is_last;
	} line_bit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        line_level;
	logic        last_bit;

	line_bit_t   line_bits_q[$];
	logic        seen_cr = 1'b0;
	logic [15:0] cur_period = BIT_PERIOD_RST;
	int          mismatches = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	bit          rx_hold_on = 1'b0;
	int          rx_gap = 0;
	event        hold_kick;

	dir_row_t dir_tab[28] = '{
		'{ROW_CHAR, 16'd0,     8'h00, 1'b1, 2'd1, 20'h00200},
		'{ROW_CHAR, 16'd0,     8'hFF, 1'b1, 2'd1, 20'h003FE},
		'{ROW_CHAR, 16'd0,     8'h0A, 1'b1, 2'd2, 20'h86A14},
		'{ROW_CFG,  16'd1,     8'h00, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0D, 1'b1, 2'd1, 20'h0021A},
		'{ROW_CHAR, 16'd0,     8'h0A, 1'b1, 2'd1, 20'h00214},
		'{ROW_CHAR, 16'd0,     8'h0A, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0D, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0D, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0A, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0D, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h41, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0A, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h55, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'hAA, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h8D, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h8A, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0B, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h01, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h80, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h7F, 1'b0, 2'd0, 20'h0},
		'{ROW_CFG,  16'd0,     8'h00, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0D, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0A, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'h0A, 1'b0, 2'd0, 20'h0},
		'{ROW_CFG,  16'd65535, 8'h00, 1'b0, 2'd0, 20'h0},
		'{ROW_CHAR, 16'd0,     8'hA5, 1'b1, 2'd1, 20'h0034A},
		'{ROW_CFG,  16'd3,     8'h00, 1'b0, 2'd0, 20'h0}
	};

	uart_tx_newline_expand dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_level (line_level),
		.last_bit   (last_bit)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Advance the carriage-return flag and return the frames sent for ch.
	function automatic int expand_char(input logic [7:0] ch, output logic [19:0] bits);
		int nf;
		if (ch == CHAR_LF && !seen_cr) begin
			nf = 2;
			bits = {1'b1, CHAR_CR, 1'b0, 1'b1, CHAR_LF, 1'b0};
		end else begin
			nf = 1;
			bits = {10'h3FF, 1'b1, ch, 1'b0};
		end
		seen_cr = (ch == CHAR_CR);
		return nf;
	endfunction

	// Weight toward CR and LF so that every newline pairing shows up often.
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				return CHAR_CR;
			end
			3, 4, 5: begin
				return CHAR_LF;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic typed, input logic [1:0] typed_nf,
			input logic [19:0] typed_bits);
		logic [19:0] bits;
		line_bit_t   lb;
		int          nf;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		nf = expand_char(ch, bits);
		if (typed) begin
			nf = typed_nf;
			bits = typed_bits;
		end
		for (int i = 0; i < nf * FRAME_BITS; i++) begin
			lb.level = bits[i];
			lb.is_last = (i == nf * FRAME_BITS - 1);
			line_bits_q.push_back(lb);
		end
	endtask

	// Hold input until the line is quiet; the stop bit may still be timing out.
	task automatic drain_line();
		in_valid <= 1'b0;
		while (line_bits_q.size() != 0) @(posedge clk);
		repeat (int'(cur_period) + 16) @(posedge clk);
	endtask

	task automatic write_period(input logic [15:0] p);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_period = p;
	endtask

	always @(posedge clk) begin
		if (!arst_n || rx_hold_on) begin
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			out_ready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			rx_gap <= $urandom_range(0, 7);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Long receiver hold-off so the request queue fills and input stalls.
	initial forever begin
		@(hold_kick);
		rx_hold_on <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		line_bit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (line_bits_q.size() == 0) begin
				$display("%0t: unexpected bit, level %0b last_bit %0b", $time, line_level,
					last_bit);
				mismatches++;
			end else begin
				want = line_bits_q.pop_front();
				if (line_level !== want.level) begin
					$display("%0t: line_level expected %0b actual %0b", $time, want.level,
						line_level);
					mismatches++;
				end
				if (last_bit !== want.is_last) begin
					$display("%0t: last_bit expected %0b actual %0b", $time, want.is_last,
						last_bit);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r]) begin
			if (dir_tab[r].kind == ROW_CFG) begin
				drain_line();
				write_period(dir_tab[r].period);
			end else begin
				send_char(dir_tab[r].ch, dir_tab[r].typed, dir_tab[r].frames, dir_tab[r].bits);
			end
		end

		for (int seg = 0; seg < 5; seg++) begin
			drain_line();
			write_period(seg == 3 ? 16'($urandom_range(6, 40)) : 16'($urandom_range(0, 3)));
			tx_idle_on = (seg != 1 && seg != 4);
			rx_idle_on <= (seg != 4);
			if (seg == 1)
				-> hold_kick;
			for (int k = 0; k < 20; k++)
				send_char(pick_char(), 1'b0, 2'd0, 20'h0);
		end

		drain_line();
		if (mismatches == 0)
			$display("** uart_tx_newline_expand: PASSED **");
		else
			$display("** uart_tx_newline_expand: FAILED **");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("** uart_tx_newline_expand: FAILED **");
		$finish;
	end

endmodule
